FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every sampled edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/swbi_pkg.sv
// Shared types and constants for the stack with bulk increment
`default_nettype none

package swbi_pkg;

  localparam int STACK_DEPTH_DEFAULT = 1024;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 11;
  localparam int BC_W   = 16;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_INC  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_INC
  } act_t;

  // controller to datapath
  typedef struct packed {
    logic            capture;
    logic            commit;
    act_t            act;
    logic [ST_W-1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic no_reach;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/stack_with_bulk_increment_core.sv
// Top level of the stack with bulk increment
`default_nettype none

// Each command (push, pop, increment of the bottom entries) runs as follows:
// the accept cycle reads the value and pending memories, and the following
// cycle, with busy high, writes back and registers the result. The result
// shows on popped_value and status with done high for exactly one cycle,
// in the cycle after busy, and cannot be held off. A new command may be
// accepted in that same cycle; none is taken while busy, since the
// synchronous pending memory must be read before it is written back.
// Memories need no clearing after reset; an entry is only read after a
// push has written it. capacity_limit (cfg_wr_data) may be written at any
// idle moment and is clamped to STACK_DEPTH.
module stack_with_bulk_increment_core #(
  parameter int STACK_DEPTH = swbi_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [swbi_pkg::OP_W-1:0]          operation,
  input  wire logic signed [swbi_pkg::DATA_W-1:0] operand_value,
  input  wire logic [swbi_pkg::BC_W-1:0]          bottom_count,
  input  wire logic                               cfg_wr_en,
  input  wire logic [swbi_pkg::CAP_W-1:0]         cfg_wr_data,
  output logic                                    done,
  output logic signed [swbi_pkg::DATA_W-1:0]      popped_value,
  output logic [swbi_pkg::ST_W-1:0]               status
);

  swbi_pkg::cmd_t  cmd;
  swbi_pkg::stat_t stat;

  swbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  swbi_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .operand_value (operand_value),
    .bottom_count  (bottom_count),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .popped_value  (popped_value),
    .status        (status)
  );

endmodule

`default_nettype wire

FILE: rtl/swbi_ctrl.sv
// Controller: accepts commands, decides the action and sequences the commit
`default_nettype none

module swbi_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [swbi_pkg::OP_W-1:0] operation,
  input  wire swbi_pkg::stat_t           stat,
  output swbi_pkg::cmd_t                 cmd,
  output logic                           busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  swbi_pkg::act_t              act;
  swbi_pkg::act_t              act_next;
  logic [swbi_pkg::ST_W-1:0]   code;
  logic [swbi_pkg::ST_W-1:0]   code_next;
  logic                        accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state == S_EXEC);

  always_comb begin
    act_next  = swbi_pkg::ACT_NONE;
    code_next = swbi_pkg::ST_DONE;
    case (operation)
      swbi_pkg::OP_PUSH: begin
        if (stat.full) begin
          code_next = swbi_pkg::ST_FULL;
        end else begin
          act_next = swbi_pkg::ACT_PUSH;
        end
      end
      swbi_pkg::OP_POP: begin
        if (stat.empty) begin
          code_next = swbi_pkg::ST_EMPTY;
        end else begin
          act_next = swbi_pkg::ACT_POP;
        end
      end
      swbi_pkg::OP_INC: begin
        if (stat.empty) begin
          code_next = swbi_pkg::ST_EMPTY;
        end else if (!stat.no_reach) begin
          act_next = swbi_pkg::ACT_INC;
        end
      end
      default: begin
        act_next  = swbi_pkg::ACT_NONE;
        code_next = swbi_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= act_next;
      code <= code_next;
    end
  end

  assign cmd.capture = accept;
  assign cmd.commit  = (state == S_EXEC);
  assign cmd.act     = act;
  assign cmd.code    = code;

endmodule

`default_nettype wire

FILE: rtl/swbi_datapath.sv
// Datapath: entry count, value and pending memories, result registers
`default_nettype none

module swbi_datapath #(
  parameter int STACK_DEPTH = swbi_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire swbi_pkg::cmd_t                     cmd,
  output swbi_pkg::stat_t                         stat,
  input  wire logic [swbi_pkg::OP_W-1:0]          operation,
  input  wire logic signed [swbi_pkg::DATA_W-1:0] operand_value,
  input  wire logic [swbi_pkg::BC_W-1:0]          bottom_count,
  input  wire logic                               cfg_wr_en,
  input  wire logic [swbi_pkg::CAP_W-1:0]         cfg_wr_data,
  output logic                                    done,
  output logic signed [swbi_pkg::DATA_W-1:0]      popped_value,
  output logic [swbi_pkg::ST_W-1:0]               status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int LW = (CW > swbi_pkg::CAP_W) ? CW : swbi_pkg::CAP_W;
  localparam int RW = (CW > swbi_pkg::BC_W) ? CW : swbi_pkg::BC_W;
  localparam int DW = swbi_pkg::DATA_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);

  logic [DW-1:0] value_mem   [STACK_DEPTH];
  logic [DW-1:0] pending_mem [STACK_DEPTH];

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [swbi_pkg::CAP_W-1:0] capacity;

  logic [DW-1:0] val_q;
  logic [DW-1:0] pend_a;
  logic [DW-1:0] pend_b;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] operand_q;
  logic          has_below;

  logic [LW-1:0] cap_ext;
  logic [LW-1:0] limit;
  logic [RW-1:0] bc_r;
  logic [RW-1:0] cnt_r;
  logic [RW-1:0] reach;
  logic [RW-1:0] reach_m1;
  logic [CW-1:0] top;
  logic [CW-1:0] below;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] wr_addr_d;
  logic          pend_we;
  logic [DW-1:0] pend_wdata;

  always_comb begin
    cap_ext  = LW'(capacity);
    limit    = (cap_ext < DEPTH_L) ? cap_ext : DEPTH_L;
    bc_r     = RW'(bottom_count);
    cnt_r    = RW'(count);
    reach    = (bc_r < cnt_r) ? bc_r : cnt_r;
    reach_m1 = reach - RW'(1);
    top      = count - CW'(1);
    below    = count - CW'(2);
  end

  assign stat.empty    = (count == '0);
  assign stat.full     = (LW'(count) >= limit);
  assign stat.no_reach = (bottom_count == '0);

  assign rd_addr_a = (operation == swbi_pkg::OP_POP) ? top[AW-1:0] : reach_m1[AW-1:0];

  always_comb begin
    case (operation)
      swbi_pkg::OP_PUSH: wr_addr_d = count[AW-1:0];
      swbi_pkg::OP_POP:  wr_addr_d = below[AW-1:0];
      default:           wr_addr_d = reach_m1[AW-1:0];
    endcase
  end

  // pop folds the top pending word into the entry below
  always_comb begin
    pend_we    = 1'b0;
    pend_wdata = '0;
    if (cmd.commit) begin
      case (cmd.act)
        swbi_pkg::ACT_PUSH: pend_we = 1'b1;
        swbi_pkg::ACT_POP: begin
          pend_we    = has_below;
          pend_wdata = pend_b + pend_a;
        end
        swbi_pkg::ACT_INC: begin
          pend_we    = 1'b1;
          pend_wdata = pend_a + operand_q;
        end
        default: pend_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.commit && cmd.act == swbi_pkg::ACT_PUSH) count_next = count + CW'(1);
    if (cmd.commit && cmd.act == swbi_pkg::ACT_POP)  count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_q  <= value_mem[top[AW-1:0]];
      pend_a <= pending_mem[rd_addr_a];
      pend_b <= pending_mem[below[AW-1:0]];
    end
    if (cmd.commit && cmd.act == swbi_pkg::ACT_PUSH) value_mem[wr_addr] <= operand_q;
    if (pend_we) pending_mem[wr_addr] <= pend_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= swbi_pkg::CAP_RESET;
      done     <= 1'b0;
    end else begin
      if (cfg_wr_en) capacity <= cfg_wr_data;
      count <= count_next;
      done  <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wr_addr   <= wr_addr_d;
      operand_q <= operand_value;
      has_below <= (count > CW'(1));
    end
    if (cmd.commit) begin
      popped_value <= (cmd.act == swbi_pkg::ACT_POP) ? $signed(val_q + pend_a) : '0;
      status       <= cmd.code;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swbi_checker.sv
// Port-level checks on command sequencing and results, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module swbi_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               done,
  input wire logic signed [swbi_pkg::DATA_W-1:0] popped_value,
  input wire logic [swbi_pkg::ST_W-1:0]          status
);

  logic accept;

  assign accept = start && !busy;

  // a transfer in occupies exactly one busy cycle, then the result follows
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `ASSERT_NEXT(a_busy_single, clk, rst, busy, !busy && done)
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `ASSERT_SAME(a_fail_zero, clk, rst, done && status != swbi_pkg::ST_DONE, popped_value == '0)
  `ASSERT_SAME(a_status_code, clk, rst, done, status <= swbi_pkg::ST_EMPTY)

endmodule

bind stack_with_bulk_increment_core swbi_checker u_swbi_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .popped_value (popped_value),
  .status       (status)
);

`default_nettype wire

FILE: tb/sv/stack_with_bulk_increment_core_test.sv
// Self-checking testbench for the stack with bulk increment core
module stack_with_bulk_increment_core_test;

  localparam int DEPTH = swbi_pkg::STACK_DEPTH_DEFAULT;
  localparam int OW    = swbi_pkg::OP_W;
  localparam int DW    = swbi_pkg::DATA_W;
  localparam int BW    = swbi_pkg::BC_W;
  localparam int SW    = swbi_pkg::ST_W;
  localparam int CAPW  = swbi_pkg::CAP_W;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [OW-1:0] op;
    logic [DW-1:0] val;      // operand, or the new capacity on a register row
    logic [BW-1:0] cnt;
    logic          pinned;   // expected reply typed in below, not predicted
    logic [DW-1:0] want_val;
    logic [SW-1:0] want_st;
  } script_row_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic [SW-1:0]        code;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OW-1:0] operation = swbi_pkg::OP_NOP;
  logic signed [DW-1:0] operand_value = '0;
  logic [BW-1:0] bottom_count = '0;
  logic cfg_wr_en = 1'b0;
  logic [CAPW-1:0] cfg_wr_data = '0;
  logic busy;
  logic done;
  logic signed [DW-1:0] popped_value;
  logic [SW-1:0] status;

  // Typed-in expectation travelling alongside the command
  logic pin_flag = 1'b0;
  logic [DW-1:0] pin_val = '0;
  logic [SW-1:0] pin_code = swbi_pkg::ST_DONE;

  // Shadow copy of the stack
  logic [DW-1:0] stack_value [DEPTH];
  logic [DW-1:0] stack_pending [DEPTH];
  int unsigned entry_total;
  logic [CAPW-1:0] cap_reg;

  reply_t awaited_replies[$];
  script_row_t script_rows[$];
  int unsigned fail_count = 0;

  int unsigned phase_cap [7] = '{2047, 8, 1, 1024, 0, 0, 3};
  int unsigned phase_idle [7] = '{0, 86, 0, 30, 0, 86, 30};
  int unsigned phase_items [7] = '{120, 100, 60, 150, 30, 120, 120};

  stack_with_bulk_increment_core #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .operand_value(operand_value),
    .bottom_count(bottom_count),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .done(done),
    .popped_value(popped_value),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic reply_t next_stack_reply(input logic [OW-1:0] op,
                                              input logic [DW-1:0] amount,
                                              input logic [BW-1:0] reach_req);
    reply_t r;
    int unsigned lim;
    int unsigned top;
    int unsigned reach;
    r.value = '0;
    r.code = swbi_pkg::ST_DONE;
    lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (op)
      swbi_pkg::OP_PUSH: begin
        // a limit lowered below the count also refuses the push
        if (entry_total >= lim) begin
          r.code = swbi_pkg::ST_FULL;
        end else begin
          stack_value[entry_total] = amount;
          stack_pending[entry_total] = '0;
          entry_total++;
        end
      end
      swbi_pkg::OP_POP: begin
        if (entry_total == 0) begin
          r.code = swbi_pkg::ST_EMPTY;
        end else begin
          top = entry_total - 1;
          r.value = stack_value[top] + stack_pending[top];
          // hand the pending amount down to the entry below
          if (top > 0) stack_pending[top-1] = stack_pending[top-1] + stack_pending[top];
          entry_total = top;
        end
      end
      swbi_pkg::OP_INC: begin
        if (entry_total == 0) begin
          r.code = swbi_pkg::ST_EMPTY;
        end else if (reach_req != 0) begin
          reach = (reach_req > entry_total) ? entry_total : reach_req;
          stack_pending[reach-1] = stack_pending[reach-1] + amount;
        end
      end
      default: r.code = swbi_pkg::ST_DONE;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    reply_t want;
    if (rst) begin
      entry_total = 0;
      cap_reg = swbi_pkg::CAP_RESET;
      awaited_replies.delete();
    end else begin
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $error("result with none awaited: popped_value %0d, status %0d",
                 popped_value, status);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (popped_value !== want.value) begin
            $error("popped_value: expected %0d, got %0d", want.value, popped_value);
            fail_count++;
          end
          if (status !== want.code) begin
            $error("status: expected %0d, got %0d", want.code, status);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (start && !busy) begin
        want = next_stack_reply(operation, operand_value, bottom_count);
        if (pin_flag) begin
          want.value = pin_val;
          want.code = pin_code;
        end
        awaited_replies.insert(awaited_replies.size(), want);
      end
    end
  end

  function automatic logic [OW-1:0] junk_op();
    return OW'($urandom_range(0, 3));
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [OW-1:0] op,
                                  input logic [DW-1:0] val, input logic [BW-1:0] cnt,
                                  input logic pinned, input logic [SW-1:0] want_st);
    script_row_t row;
    row.kind = kind;
    row.op = op;
    row.val = val;
    row.cnt = cnt;
    row.pinned = pinned;
    row.want_val = '0;
    row.want_st = want_st;
    script_rows.insert(script_rows.size(), row);
  endfunction

  // Hold the command until the transfer, then idle for a random stretch
  task automatic issue(input script_row_t row, input int unsigned idle_pct);
    start <= 1'b1;
    operation <= row.op;
    operand_value <= row.val;
    bottom_count <= row.cnt;
    pin_flag <= row.pinned;
    pin_val <= row.want_val;
    pin_code <= row.want_st;
    do @(posedge clk); while (busy);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      operation <= junk_op();
      operand_value <= $urandom();
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAPW-1:0] cap);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    script_row_t row;
    int unsigned ph;
    int unsigned k;
    int unsigned r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack, no-op, extremes, zero and clamped reach, full and lowered limits
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b1, swbi_pkg::ST_EMPTY);
    add_row(ROW_CMD, swbi_pkg::OP_INC,  32'h5,        16'hFFFF, 1'b1, swbi_pkg::ST_EMPTY);
    add_row(ROW_CMD, swbi_pkg::OP_NOP,  32'hFFFFFFFF, 16'hFFFF, 1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'h7FFFFFFF, 16'h0,    1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'h80000000, 16'h0,    1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'hFFFFFFFF, 16'h0,    1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_INC,  32'd123,      16'h0,    1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_INC,  32'h1,        16'hFFFF, 1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_INC,  32'h7FFFFFFF, 16'h1,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_INC,  32'h80000000, 16'h2,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b1, swbi_pkg::ST_EMPTY);
    add_row(ROW_CFG, swbi_pkg::OP_NOP,  32'd2,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'hAAAA5555, 16'h0,    1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'h5555AAAA, 16'h0,    1'b1, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'h1,        16'h0,    1'b1, swbi_pkg::ST_FULL);
    add_row(ROW_CFG, swbi_pkg::OP_NOP,  32'd1,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'h2,        16'h0,    1'b1, swbi_pkg::ST_FULL);
    add_row(ROW_CFG, swbi_pkg::OP_NOP,  32'd0,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_PUSH, 32'h3,        16'h0,    1'b1, swbi_pkg::ST_FULL);
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CMD, swbi_pkg::OP_POP,  32'h0,        16'h0,    1'b0, swbi_pkg::ST_DONE);
    add_row(ROW_CFG, swbi_pkg::OP_NOP,  32'd2047,     16'h0,    1'b0, swbi_pkg::ST_DONE);

    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_CFG) write_capacity(script_rows[i].val[CAPW-1:0]);
      else issue(script_rows[i], 30);
    end

    for (ph = 0; ph < 7; ph++) begin
      write_capacity((ph == 5) ? CAPW'($urandom_range(2, 40)) : CAPW'(phase_cap[ph]));
      for (k = 0; k < phase_items[ph]; k++) begin
        r = $urandom_range(0, 99);
        row.kind = ROW_CMD;
        row.op = (r < 42) ? swbi_pkg::OP_PUSH :
                 (r < 72) ? swbi_pkg::OP_POP :
                 (r < 95) ? swbi_pkg::OP_INC : swbi_pkg::OP_NOP;
        case ($urandom_range(0, 9))
          0: row.val = 32'h7FFFFFFF;
          1: row.val = 32'h80000000;
          2: row.val = 32'hFFFFFFFF;
          default: row.val = $urandom();
        endcase
        // mostly reach inside a shallow stack, sometimes anywhere in the field
        row.cnt = ($urandom_range(0, 9) < 7) ? BW'($urandom_range(0, 12)) :
                                               BW'($urandom_range(0, 65535));
        row.pinned = 1'b0;
        row.want_val = '0;
        row.want_st = swbi_pkg::ST_DONE;
        issue(row, phase_idle[ph]);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
